// ===== rtl/assert_macros.svh =====
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define SCL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, off during reset
`define SCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/scl_pkg.sv =====
// shared types, character codes and constants of the servo command parser
`timescale 1ns / 1ps
package scl_pkg;

  localparam int LINE_DEPTH_DEFAULT = 16;

  // configuration port
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NARROW_MIN  = 2'd0,
    CFG_NARROW_SPAN = 2'd1,
    CFG_WIDE_MIN    = 2'd2,
    CFG_WIDE_SPAN   = 2'd3
  } cfg_index_t;

  localparam logic [7:0] NARROW_MIN_RST  = 8'd8;
  localparam logic [7:0] NARROW_SPAN_RST = 8'd30;
  localparam logic [9:0] WIDE_MIN_RST    = 10'd125;
  localparam logic [9:0] WIDE_SPAN_RST   = 10'd500;

  // character codes
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_VT      = 8'd11;
  localparam logic [7:0] CH_FF      = 8'd12;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_PLUS    = 8'd43;
  localparam logic [7:0] CH_MINUS   = 8'd45;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_COLON   = 8'd58;
  localparam logic [7:0] CH_SEMI    = 8'd59;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_D = 8'd68;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_D = 8'd100;

  localparam logic [7:0] ANGLE_MAX = 8'd180;

  // x / 180 == (x >> 2) / 45, and (y * 93207) >> 22 is exact for 16-bit y
  localparam logic [16:0] DIV45_MULT  = 17'd93207;
  localparam int          DIV45_SHIFT = 22;

  typedef enum logic [2:0] {
    PH_SKIP = 3'b001,
    PH_NUM  = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] narrow_min;
    logic [7:0] narrow_span;
    logic [9:0] wide_min;
    logic [9:0] wide_span;
  } pulse_cfg_t;

  typedef struct packed {
    logic [1:0] servo;
    logic [7:0] angle;
  } cmd_t;

  // servos 0 and 3 sit on 8-bit timers
  function automatic logic is_narrow(input logic [1:0] servo);
    return (servo == 2'd0) || (servo == 2'd3);
  endfunction

endpackage

// ===== rtl/scl_if.sv =====
// valid/ready channel interfaces for received bytes and servo results
`timescale 1ns / 1ps
interface scl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface scl_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  servo_index;
  logic [7:0]  angle_degrees;
  logic [10:0] compare_value;
  modport source (output valid, output servo_index, output angle_degrees,
                  output compare_value, input ready);
  modport sink (input valid, input servo_index, input angle_degrees,
                input compare_value, output ready);
endinterface

// ===== rtl/scl_line_parser.sv =====
// per-byte line state update and command register
`timescale 1ns / 1ps
module scl_line_parser
  import scl_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       cmd_valid,
  output cmd_t       cmd
);

  localparam int CW = $clog2(LINE_DEPTH);

  logic [CW-1:0] char_count, char_count_next;
  logic [7:0]    id_char, id_char_next;
  logic          separator_seen, separator_seen_next;
  phase_t        number_phase, number_phase_next;
  logic          number_negative, number_negative_next;
  logic [7:0]    number_accumulator, number_accumulator_next;

  logic       accept, eol, is_digit, is_space, id_hit, hit;
  logic [1:0] servo;
  logic [7:0] angle_raw, angle, acc_step;

  assign in_ready = !cmd_valid || advance;
  assign accept   = in_valid && in_ready;

  always_comb begin
    eol      = (rx_byte == CH_LF) || (rx_byte == CH_CR);
    is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    is_space = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) ||
               (rx_byte == CH_VT) || (rx_byte == CH_FF);
    // acc * 10 + digit, modulo 256
    acc_step = (number_accumulator << 3) + (number_accumulator << 1) + (rx_byte - CH_ZERO);

    id_hit = 1'b0;
    servo  = 2'd0;
    if ((id_char >= CH_UPPER_A) && (id_char <= CH_UPPER_D)) begin
      id_hit = 1'b1;
      servo  = 2'(id_char - CH_UPPER_A);
    end else if ((id_char >= CH_LOWER_A) && (id_char <= CH_LOWER_D)) begin
      id_hit = 1'b1;
      servo  = 2'(id_char - CH_LOWER_A);
    end

    angle_raw = number_negative ? (8'd0 - number_accumulator) : number_accumulator;
    angle     = (angle_raw > ANGLE_MAX) ? ANGLE_MAX : angle_raw;
    hit       = eol && (char_count >= CW'(3)) && separator_seen && id_hit;

    char_count_next         = char_count;
    id_char_next            = id_char;
    separator_seen_next     = separator_seen;
    number_phase_next       = number_phase;
    number_negative_next    = number_negative;
    number_accumulator_next = number_accumulator;

    if (eol || (char_count >= CW'(LINE_DEPTH - 1))) begin
      // end of line or overflow: start over empty
      char_count_next         = '0;
      id_char_next            = 8'd0;
      separator_seen_next     = 1'b0;
      number_phase_next       = PH_SKIP;
      number_negative_next    = 1'b0;
      number_accumulator_next = 8'd0;
    end else begin
      char_count_next = char_count + CW'(1);
      if (char_count == CW'(0)) begin
        id_char_next = rx_byte;
      end else if (char_count == CW'(1)) begin
        separator_seen_next = (rx_byte == CH_COLON) || (rx_byte == CH_SEMI);
      end else begin
        unique case (number_phase)
          PH_SKIP: begin
            if (is_space) begin
              number_phase_next = PH_SKIP;
            end else if ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS)) begin
              number_negative_next = (rx_byte == CH_MINUS);
              number_phase_next    = PH_NUM;
            end else if (is_digit) begin
              number_accumulator_next = acc_step;
              number_phase_next       = PH_NUM;
            end else begin
              number_phase_next = PH_DONE;
            end
          end
          PH_NUM: begin
            if (is_digit) begin
              number_accumulator_next = acc_step;
            end else begin
              number_phase_next = PH_DONE;
            end
          end
          PH_DONE: begin
            number_phase_next = PH_DONE;
          end
          default: begin
            number_phase_next = PH_DONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count         <= '0;
      id_char            <= 8'd0;
      separator_seen     <= 1'b0;
      number_phase       <= PH_SKIP;
      number_negative    <= 1'b0;
      number_accumulator <= 8'd0;
    end else if (accept) begin
      char_count         <= char_count_next;
      id_char            <= id_char_next;
      separator_seen     <= separator_seen_next;
      number_phase       <= number_phase_next;
      number_negative    <= number_negative_next;
      number_accumulator <= number_accumulator_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept && hit) begin
      cmd_valid <= 1'b1;
    end else if (advance) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hit) begin
      cmd.servo <= servo;
      cmd.angle <= angle;
    end
  end

endmodule

// ===== rtl/scl_pulse_calc.sv =====
// compare value pipeline: span multiply, divide by 180, add minimum
`timescale 1ns / 1ps
module scl_pulse_calc
  import scl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        advance,
  input  pulse_cfg_t  cfg,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  servo_index,
  output logic [7:0]  angle_degrees,
  output logic [10:0] compare_value
);

  logic        prod_valid, quot_valid;
  cmd_t        prod_cmd, quot_cmd;
  logic [17:0] product;
  logic [9:0]  quotient;
  logic [9:0]  span_sel;
  logic [10:0] min_sel;
  logic [32:0] recip_prod;
  logic        en_out, en_quot, en_prod;

  assign en_out  = !out_valid || out_ready;
  assign en_quot = !quot_valid || en_out;
  assign en_prod = !prod_valid || en_quot;
  assign advance = en_prod;

  assign span_sel   = is_narrow(cmd.servo) ? {2'b00, cfg.narrow_span} : cfg.wide_span;
  assign recip_prod = product[17:2] * DIV45_MULT;
  assign min_sel    = is_narrow(quot_cmd.servo) ? {3'b000, cfg.narrow_min}
                                                 : {1'b0, cfg.wide_min};

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      quot_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (en_prod) begin
        prod_valid <= cmd_valid;
      end
      if (en_quot) begin
        quot_valid <= prod_valid;
      end
      if (en_out) begin
        out_valid <= quot_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_prod) begin
      prod_cmd <= cmd;
      product  <= cmd.angle * span_sel;
    end
    if (en_quot) begin
      quot_cmd <= prod_cmd;
      quotient <= recip_prod[DIV45_SHIFT +: 10];
    end
    if (en_out) begin
      servo_index   <= quot_cmd.servo;
      angle_degrees <= quot_cmd.angle;
      compare_value <= min_sel + {1'b0, quotient};
    end
  end

endmodule

// ===== rtl/servo_command_line_parser.sv =====
// top level of the servo command line parser
// usage:
//   rx carries one received character per transaction (rx_byte); result
//   carries one servo command per transaction: servo_index, angle_degrees
//   and compare_value for that servo's timer channel
//   cfg_we/cfg_index/cfg_data write the pulse min and span registers;
//   write them only while no command is in flight
// throughput: one character per cycle; the line state is updated in the
//   cycle the character is taken, so back-to-back characters never stall
//   while the result side keeps up
// path: a terminating CR or LF produces its result through the command
//   register, span multiply, reciprocal divide by 180, then minimum add
//   into the output register
// lines that are short, malformed or name no servo A-D end silently
// reset: synchronous, clears the line state, all pipeline valid flags, and
//   loads the default pulse registers 8, 30, 125, 500
// stall: a held result keeps its value; stages behind it fill up and rx
//   drops ready only once the command register itself cannot move on
module servo_command_line_parser
  import scl_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  scl_byte_if.sink              rx,
  scl_result_if.source          result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  pulse_cfg_t cfg;
  logic       cmd_valid;
  cmd_t       cmd;
  logic       advance;

  // pulse shaping registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.narrow_min  <= NARROW_MIN_RST;
      cfg.narrow_span <= NARROW_SPAN_RST;
      cfg.wide_min    <= WIDE_MIN_RST;
      cfg.wide_span   <= WIDE_SPAN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_NARROW_MIN:  cfg.narrow_min  <= cfg_data[7:0];
        CFG_NARROW_SPAN: cfg.narrow_span <= cfg_data[7:0];
        CFG_WIDE_MIN:    cfg.wide_min    <= cfg_data;
        CFG_WIDE_SPAN:   cfg.wide_span   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // character-by-character line parsing
  scl_line_parser #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .rx_byte   (rx.rx_byte),
    .advance   (advance),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // angle to compare value
  scl_pulse_calc u_calc (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .advance       (advance),
    .cfg           (cfg),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .servo_index   (result.servo_index),
    .angle_degrees (result.angle_degrees),
    .compare_value (result.compare_value)
  );

endmodule

// ===== rtl/scl_checker.sv =====
// port-level checks for the servo command line parser, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scl_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  servo_index,
  input logic [7:0]  angle_degrees,
  input logic [10:0] compare_value
);

  logic [20:0] payload;
  logic        narrow_out;

  assign payload    = {servo_index, angle_degrees, compare_value};
  assign narrow_out = out_valid && (servo_index == 2'd0 || servo_index == 2'd3);

  // results wait for the receiver with a steady payload
  `SCL_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(payload))

  // angle is clamped
  `SCL_ASSERT_SAME(a_angle_clamp, clk, rst, out_valid, angle_degrees <= 8'd180)

  // 8-bit timer servos never exceed 255 + 255
  `SCL_ASSERT_SAME(a_narrow_range, clk, rst, narrow_out, compare_value <= 11'd510)

endmodule

bind servo_command_line_parser scl_checker u_scl_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .servo_index   (result.servo_index),
  .angle_degrees (result.angle_degrees),
  .compare_value (result.compare_value)
);

// ===== dv/scl_command_checker.sv =====
// checker that predicts servo commands from received bytes and compares results
`timescale 1ns / 1ps
module scl_command_checker
  import scl_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  scl_byte_if                   rx,
  scl_result_if                 result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic [1:0]  servo;
    logic [7:0]  angle;
    logic [10:0] compare;
  } servo_cmd_t;

  servo_cmd_t pending_cmds[$];
  pulse_cfg_t pulse;
  int         fail_total = 0;

  // line state
  int         held_chars;
  logic [7:0] lead_char;
  logic       sep_ok;
  phase_t     num_phase;
  logic       num_neg;
  logic [7:0] num_mag;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    fail_total++;
  endtask

  task automatic clear_line();
    held_chars = 0;
    lead_char  = '0;
    sep_ok     = 1'b0;
    num_phase  = PH_SKIP;
    num_neg    = 1'b0;
    num_mag    = '0;
  endtask

  task automatic feed_number(input logic [7:0] c);
    logic taken;
    taken = 1'b0;
    if (num_phase == PH_SKIP) begin
      if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
        taken = 1'b1;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
        num_neg   = (c == CH_MINUS);
        num_phase = PH_NUM;
        taken     = 1'b1;
      end else begin
        num_phase = PH_NUM;
      end
    end
    if (!taken && num_phase == PH_NUM) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        num_mag = num_mag * 8'd10 + (c - CH_ZERO);
      end else begin
        num_phase = PH_DONE;
      end
    end
  endtask

  // end of line: queue a command if the line is long enough, has a separator and names a servo
  task automatic close_line();
    servo_cmd_t  cmd;
    logic        named;
    logic [7:0]  ang;
    int unsigned scaled;
    named = 1'b1;
    if (lead_char >= CH_UPPER_A && lead_char <= CH_UPPER_D) begin
      cmd.servo = 2'(lead_char - CH_UPPER_A);
    end else if (lead_char >= CH_LOWER_A && lead_char <= CH_LOWER_D) begin
      cmd.servo = 2'(lead_char - CH_LOWER_A);
    end else begin
      named = 1'b0;
    end
    if (held_chars >= 3 && sep_ok && named) begin
      ang = num_neg ? (8'd0 - num_mag) : num_mag;
      if (ang > ANGLE_MAX) begin
        ang = ANGLE_MAX;
      end
      cmd.angle = ang;
      if (cmd.servo == 2'd0 || cmd.servo == 2'd3) begin
        scaled      = int'(ang) * int'(pulse.narrow_span) / int'(ANGLE_MAX);
        cmd.compare = 11'(int'(pulse.narrow_min) + scaled);
      end else begin
        scaled      = int'(ang) * int'(pulse.wide_span) / int'(ANGLE_MAX);
        cmd.compare = 11'(int'(pulse.wide_min) + scaled);
      end
      pending_cmds.push_back(cmd);
    end
    clear_line();
  endtask

  task automatic parse_char(input logic [7:0] c);
    if (c == CH_LF || c == CH_CR) begin
      close_line();
    end else if (held_chars < LINE_DEPTH - 1) begin
      if (held_chars == 0) begin
        lead_char = c;
      end else if (held_chars == 1) begin
        sep_ok = (c == CH_COLON || c == CH_SEMI);
      end else begin
        feed_number(c);
      end
      held_chars++;
    end else begin
      // line overflow drops this character and starts over
      clear_line();
    end
  endtask

  always @(posedge clk) begin : watch
    servo_cmd_t want;
    if (rst) begin
      clear_line();
      pulse = '{NARROW_MIN_RST, NARROW_SPAN_RST, WIDE_MIN_RST, WIDE_SPAN_RST};
      pending_cmds.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NARROW_MIN:  pulse.narrow_min  = cfg_data[7:0];
          CFG_NARROW_SPAN: pulse.narrow_span = cfg_data[7:0];
          CFG_WIDE_MIN:    pulse.wide_min    = cfg_data;
          CFG_WIDE_SPAN:   pulse.wide_span   = cfg_data;
          default: ;
        endcase
      end
      if (rx.valid && rx.ready) begin
        parse_char(rx.rx_byte);
      end
      if (result.valid && result.ready) begin
        if (pending_cmds.size() == 0) begin
          report_mismatch("result with no command pending, servo",
                          int'(result.servo_index), -1);
        end else begin
          want = pending_cmds.pop_front();
          if (result.servo_index !== want.servo) begin
            report_mismatch("servo_index", int'(result.servo_index), int'(want.servo));
          end
          if (result.angle_degrees !== want.angle) begin
            report_mismatch("angle_degrees", int'(result.angle_degrees), int'(want.angle));
          end
          if (result.compare_value !== want.compare) begin
            report_mismatch("compare_value", int'(result.compare_value),
                            int'(want.compare));
          end
        end
      end
    end
    mismatches  <= fail_total;
    outstanding <= pending_cmds.size();
  end

endmodule

// ===== dv/tb.sv =====
// testbench top: drives received characters and pulse settings, gives the verdict
`timescale 1ns / 1ps
module tb;
  import scl_pkg::*;

  localparam logic [7:0] CH_NUL = 8'h00;
  // cycles to let the pipeline empty after the last expected command
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PER_PHASE = 70;
  localparam int PHASES = 6;

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    outstanding;

  // no-idle stretches for both sides
  logic quiet = 1'b0;
  int   sent_count = 0;

  scl_byte_if   rx_ch ();
  scl_result_if result_ch ();

  servo_command_line_parser dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  scl_command_checker cmd_check (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx_ch),
    .result      (result_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #1000000;
    $display("tb NOT OK");
    $finish;
  end

  // idle cycles before the next transaction on either side
  function automatic int draw_gap();
    if (quiet || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // result side: a random stall per command, then ready until the transaction
  initial begin : result_sink
    int gap;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(result_ch.valid && result_ch.ready)) @(posedge clk);
    end
  end

  // one character, held until the transaction completes
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= c;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
  endtask

  // stop sending and wait until every predicted command has come out
  task automatic drain();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all four pulse registers back to back, only while idle
  task automatic load_pulse(input logic [9:0] nmin, input logic [9:0] nspan,
                            input logic [9:0] wmin, input logic [9:0] wspan);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NARROW_MIN;
    cfg_data  <= nmin;
    @(posedge clk);
    cfg_index <= CFG_NARROW_SPAN;
    cfg_data  <= nspan;
    @(posedge clk);
    cfg_index <= CFG_WIDE_MIN;
    cfg_data  <= wmin;
    @(posedge clk);
    cfg_index <= CFG_WIDE_SPAN;
    cfg_data  <= wspan;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] any_non_terminator();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CH_LF || c == CH_CR) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] servo_letter();
    return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'($urandom_range(0, 3));
  endfunction

  function automatic logic [7:0] any_whitespace();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  function automatic logic [7:0] any_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // one random line: mostly well formed commands, some broken, some
  // overflowing the line buffer, some raw noise
  task automatic send_random_line();
    logic [7:0] chars[$];
    logic [7:0] c;
    int         kind;
    int         n;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      chars.push_back(servo_letter());
      chars.push_back($urandom_range(0, 1) ? CH_COLON : CH_SEMI);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) chars.push_back(any_whitespace());
      case ($urandom_range(0, 3))
        0: chars.push_back(CH_PLUS);
        1: chars.push_back(CH_MINUS);
        default: ;
      endcase
      n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      repeat (n) chars.push_back(any_digit());
      if ($urandom_range(0, 4) == 0) begin
        chars.push_back(any_non_terminator());
        if ($urandom_range(0, 1)) chars.push_back(any_digit());
      end
    end else if (kind < 80) begin
      case ($urandom_range(0, 2))
        0: begin
          // first character names no servo
          c = any_non_terminator();
          while ((c >= CH_UPPER_A && c <= CH_UPPER_D) ||
                 (c >= CH_LOWER_A && c <= CH_LOWER_D)) c = any_non_terminator();
          chars.push_back(c);
          chars.push_back(CH_COLON);
          chars.push_back(any_digit());
        end
        1: begin
          // bad separator
          chars.push_back(servo_letter());
          c = any_non_terminator();
          while (c == CH_COLON || c == CH_SEMI) c = any_non_terminator();
          chars.push_back(c);
          chars.push_back(any_digit());
        end
        default: begin
          // too short for a command
          n = $urandom_range(0, 2);
          if (n > 0) chars.push_back(servo_letter());
          if (n > 1) chars.push_back(CH_SEMI);
        end
      endcase
    end else if (kind < 90) begin
      // lengths around the buffer limit
      chars.push_back(servo_letter());
      chars.push_back(CH_COLON);
      n = $urandom_range(LINE_DEPTH_DEFAULT - 4, LINE_DEPTH_DEFAULT + 4);
      while (chars.size() < n) begin
        chars.push_back($urandom_range(0, 2) ? any_digit() : any_non_terminator());
      end
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) chars.push_back(8'($urandom_range(0, 255)));
    end
    if (kind < 90) begin
      chars.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
    end
    foreach (chars[i]) send_char(chars[i]);
  endtask

  task automatic send_directed();
    send_str("A:0");
    send_char(CH_CR);
    // negative wraps modulo 256 and clamps
    send_str("b;-5");
    send_char(CH_LF);
    send_str("c;");
    send_char(CH_VT);
    send_str("+7");
    send_char(CH_CR);
    // null byte ends the number
    send_str("D:");
    send_char(CH_TAB);
    send_str("2");
    send_char(CH_NUL);
    send_str("4");
    send_char(CH_LF);
    // no digits gives zero
    send_str("a;");
    send_char(CH_FF);
    send_str(" x");
    send_char(CH_CR);
    // short line, no command
    send_str("B:");
    send_char(CH_LF);
  endtask

  initial begin : stimulus
    int target;
    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_NARROW_MIN;
    cfg_data      <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      // settings change only once the block is idle; phase 0 runs on reset values
      if (ph > 0) begin
        drain();
        case (ph)
          1: load_pulse('0, '0, '0, '0);
          2: load_pulse('1, '1, '1, '1);
          default: load_pulse(10'($urandom), 10'($urandom), 10'($urandom),
                              10'($urandom));
        endcase
      end
      quiet = (ph == 2 || ph == 4);
      if (ph == 0) begin
        send_directed();
      end
      target = sent_count + RANDOM_PER_PHASE;
      while (sent_count < target) send_random_line();
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
